@@ design/ius_pkg.sv @@
`timescale 1ns / 1ps

package ius_pkg;

  // Source size limits and scale ceiling
  localparam logic [10:0] MaxSrcWidth  = 11'd1024;
  localparam logic [9:0]  MaxSrcHeight = 10'd512;
  localparam logic [3:0]  MaxScale     = 4'd8;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ROW_STRIDE = 3'd4;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [3:0]  scale_h;
    logic [3:0]  scale_v;
    logic [10:0] off_h;
    logic [10:0] off_v;
    logic [10:0] clip_w;
    logic [9:0]  clip_h;
    logic [10:0] eff_w;
    logic [9:0]  eff_h;
    logic [12:0] stride;
  } ius_geom_t;

  typedef struct packed {
    logic busy;     // geometry being recomputed
    logic restart;  // register write: source position back to 0,0
  } ius_ctrl_t;

  // One in-clip source pixel: top-left word of its block and its color
  typedef struct packed {
    logic [15:0] pixel;
    logic [22:0] addr;
  } ius_job_t;

  function automatic logic [15:0] to_565(input logic [23:0] c);
    return {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

@@ design/ius_derive.sv @@
`timescale 1ns / 1ps

module ius_derive import ius_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  output ius_geom_t   geom,
  output ius_ctrl_t   ctrl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOAD  = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_OFFS  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [10:0] src_w_r;
  logic [9:0]  src_h_r;
  logic [11:0] dst_w_r, dst_h_r;
  logic [12:0] stride_r;
  logic [3:0]  sh_r, sh_nxt, sv_r, sv_nxt;
  logic [12:0] acc_h_r, acc_h_nxt, acc_v_r, acc_v_nxt;
  logic [10:0] off_h_r, off_h_nxt, off_v_r, off_v_nxt;
  logic [10:0] clip_w_r, clip_w_nxt;
  logic [9:0]  clip_h_r, clip_h_nxt;
  logic [10:0] eff_w;
  logic [9:0]  eff_h;
  logic [12:0] sum_h, sum_v;
  logic        grow_h, grow_v, wr_hit;

  always_comb begin
    if (src_w_r == 11'd0) eff_w = 11'd1;
    else if (src_w_r > MaxSrcWidth) eff_w = MaxSrcWidth;
    else eff_w = src_w_r;
    if (src_h_r == 10'd0) eff_h = 10'd1;
    else if (src_h_r > MaxSrcHeight) eff_h = MaxSrcHeight;
    else eff_h = src_h_r;
  end

  assign wr_hit = cfg_we && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT ||
                             cfg_index == REG_DST_WIDTH || cfg_index == REG_DST_HEIGHT ||
                             cfg_index == REG_ROW_STRIDE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= 11'd320;
      src_h_r  <= 10'd256;
      dst_w_r  <= 12'd640;
      dst_h_r  <= 12'd512;
      stride_r <= 13'd640;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_w_r  <= cfg_wdata[10:0];
        REG_SRC_HEIGHT: src_h_r  <= cfg_wdata[9:0];
        REG_DST_WIDTH:  dst_w_r  <= cfg_wdata[11:0];
        REG_DST_HEIGHT: dst_h_r  <= cfg_wdata[11:0];
        REG_ROW_STRIDE: stride_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // scale = largest s <= MaxScale with s*src <= dst, at least 1; one step a cycle
  assign sum_h  = acc_h_r + 13'(eff_w);
  assign sum_v  = acc_v_r + 13'(eff_h);
  assign grow_h = (sh_r < MaxScale) && (sum_h <= 13'(dst_w_r));
  assign grow_v = (sv_r < MaxScale) && (sum_v <= 13'(dst_h_r));

  always_comb begin
    state_nxt  = state_r;
    sh_nxt     = sh_r;
    sv_nxt     = sv_r;
    acc_h_nxt  = acc_h_r;
    acc_v_nxt  = acc_v_r;
    off_h_nxt  = off_h_r;
    off_v_nxt  = off_v_r;
    clip_w_nxt = clip_w_r;
    clip_h_nxt = clip_h_r;
    case (state_r)
      ST_LOAD: begin
        sh_nxt    = 4'd1;
        sv_nxt    = 4'd1;
        acc_h_nxt = 13'(eff_w);
        acc_v_nxt = 13'(eff_h);
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (grow_h) begin
          sh_nxt    = sh_r + 4'd1;
          acc_h_nxt = sum_h;
        end
        if (grow_v) begin
          sv_nxt    = sv_r + 4'd1;
          acc_v_nxt = sum_v;
        end
        if (!grow_h && !grow_v) state_nxt = ST_OFFS;
      end
      ST_OFFS: begin
        // dst below src forces scale 1 and clips to dst; otherwise acc = src * scale
        clip_w_nxt = (dst_w_r < 12'(eff_w)) ? dst_w_r[10:0] : eff_w;
        clip_h_nxt = (dst_h_r < 12'(eff_h)) ? dst_h_r[9:0] : eff_h;
        off_h_nxt  = (13'(dst_w_r) > acc_h_r) ? 11'((13'(dst_w_r) - acc_h_r) >> 1) : 11'd0;
        off_v_nxt  = (13'(dst_h_r) > acc_v_r) ? 11'((13'(dst_h_r) - acc_v_r) >> 1) : 11'd0;
        state_nxt  = ST_IDLE;
      end
      default: ;
    endcase
    if (wr_hit) state_nxt = ST_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    sh_r     <= sh_nxt;
    sv_r     <= sv_nxt;
    acc_h_r  <= acc_h_nxt;
    acc_v_r  <= acc_v_nxt;
    off_h_r  <= off_h_nxt;
    off_v_r  <= off_v_nxt;
    clip_w_r <= clip_w_nxt;
    clip_h_r <= clip_h_nxt;
  end

  assign geom.scale_h = sh_r;
  assign geom.scale_v = sv_r;
  assign geom.off_h   = off_h_r;
  assign geom.off_v   = off_v_r;
  assign geom.clip_w  = clip_w_r;
  assign geom.clip_h  = clip_h_r;
  assign geom.eff_w   = eff_w;
  assign geom.eff_h   = eff_h;
  assign geom.stride  = stride_r;

  assign ctrl.busy    = (state_r != ST_IDLE);
  assign ctrl.restart = wr_hit;

endmodule

@@ design/ius_front.sv @@
`timescale 1ns / 1ps

module ius_front import ius_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ius_geom_t   geom,
  input  ius_ctrl_t   ctrl,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  output logic        push,
  output ius_job_t    push_job,
  input  logic        q_ready
);

  logic [9:0]  col_r, col_nxt;
  logic [8:0]  row_r, row_nxt;
  logic        a_valid_r, a_valid_nxt;
  logic [11:0] a_row_r, a_col_r;
  logic [15:0] a_pix_r;
  logic        accept, in_clip, col_wrap;
  logic [13:0] col_base, row_base;
  logic [24:0] addr_full;

  assign in_tready = !ctrl.busy && (!a_valid_r || q_ready);
  assign accept    = in_tvalid && in_tready;

  assign in_clip  = (11'(col_r) < geom.clip_w) && (10'(row_r) < geom.clip_h);
  assign col_wrap = (11'(col_r) + 11'd1) >= geom.eff_w;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (ctrl.restart) begin
      col_nxt = 10'd0;
      row_nxt = 9'd0;
    end else if (accept) begin
      if (col_wrap) begin
        col_nxt = 10'd0;
        row_nxt = ((10'(row_r) + 10'd1) >= geom.eff_h) ? 9'd0 : row_r + 9'd1;
      end else begin
        col_nxt = col_r + 10'd1;
      end
    end
  end

  assign col_base = 14'(col_r) * 14'(geom.scale_h) + 14'(geom.off_h);
  assign row_base = 14'(row_r) * 14'(geom.scale_v) + 14'(geom.off_v);

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) a_valid_nxt = in_clip;
    else if (push) a_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= 10'd0;
      row_r     <= 9'd0;
      a_valid_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      a_valid_r <= a_valid_nxt;
    end
  end

  // in-clip positions stay below the framebuffer size, so 12 bits hold them
  always_ff @(posedge clk) begin
    if (accept) begin
      a_col_r <= col_base[11:0];
      a_row_r <= row_base[11:0];
      a_pix_r <= to_565(in_tdata);
    end
  end

  assign addr_full      = 25'(a_row_r) * 25'(geom.stride) + 25'(a_col_r);
  assign push           = a_valid_r && q_ready;
  assign push_job.addr  = addr_full[22:0];
  assign push_job.pixel = a_pix_r;

endmodule

@@ design/ius_queue.sv @@
`timescale 1ns / 1ps

module ius_queue import ius_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ius_job_t push_job,
  output logic     q_ready,
  input  logic     pop,
  output logic     q_valid,
  output ius_job_t q_job
);

  ius_job_t             mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QueuePtrW:0]   count_r;

  assign q_ready = (count_r < (QueuePtrW + 1)'(QueueDepth));
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

@@ design/ius_back.sv @@
`timescale 1ns / 1ps

module ius_back import ius_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ius_geom_t   geom,
  input  logic        q_valid,
  input  ius_job_t    q_job,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  logic        busy_r;
  logic [3:0]  sx_r, sy_r;
  logic [22:0] addr_r, row_addr_r;
  logic [15:0] pix_r;
  logic        out_valid_r, out_last_r;
  logic [22:0] out_addr_r;
  logic [15:0] out_pix_r;
  logic        out_load, fire, end_row, last_beat, done;
  logic [22:0] next_row;

  assign out_load  = !out_valid_r || out_tready;
  assign fire      = busy_r && out_load;
  assign end_row   = (sx_r == geom.scale_h - 4'd1);
  assign last_beat = end_row && (sy_r == geom.scale_v - 4'd1);
  assign done      = fire && last_beat;
  // next job is taken on the final beat of the current one
  assign pop       = q_valid && (!busy_r || done);
  assign next_row  = row_addr_r + 23'(geom.stride);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) busy_r <= 1'b1;
      else if (done) busy_r <= 1'b0;
      if (fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sx_r       <= 4'd0;
      sy_r       <= 4'd0;
      addr_r     <= q_job.addr;
      row_addr_r <= q_job.addr;
      pix_r      <= q_job.pixel;
    end else if (fire) begin
      if (end_row) begin
        sx_r       <= 4'd0;
        sy_r       <= sy_r + 4'd1;
        row_addr_r <= next_row;
        addr_r     <= next_row;
      end else begin
        sx_r   <= sx_r + 4'd1;
        addr_r <= addr_r + 23'd1;
      end
    end
    if (fire) begin
      out_addr_r <= addr_r;
      out_pix_r  <= pix_r;
      out_last_r <= last_beat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pix_r, out_addr_r};
  assign out_tlast  = out_last_r;

endmodule

@@ design/integer_upscaler_centered_rgb565.sv @@
`timescale 1ns / 1ps

// Nearest-neighbor integer upscaler: RGB888 source pixels in raster order
// become blocks of scale_h x scale_v RGB565 framebuffer writes.
// in_*  : one source pixel per beat, tdata = color.
// out_* : one framebuffer write per beat, tdata = word_address, pixel;
//         tlast marks the final write of a source pixel's block.
// cfg_* : register writes, index 0..4 = src_width, src_height, dst_width,
//         dst_height, row_stride. A write restarts the source position at 0,0.
// With the back end idle, a pixel's beat reaches out_tvalid through the
// front stage, the job queue, the back end's block registers and the output
// register. On the output side the block generator in the back end makes an
// in-clip pixel's writes at one write per cycle while out_tready is high;
// 2x2 scaling gives 4 writes per pixel. Out-of-clip pixels produce no writes.
// A 4-entry job queue lets the front keep taking pixels while the back end
// is busy.
// After reset and after every write to registers 0..4 the scale and centering
// offsets are recomputed, and in_tready stays low until that is done.
// When the receiver stalls, the output beat holds, the queue fills and
// in_tready drops.

module integer_upscaler_centered_rgb565 import ius_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] color
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [22:0] word_address, [38:23] pixel, [39] zero
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  ius_geom_t geom;
  ius_ctrl_t ctrl;
  ius_job_t  push_job, q_job;
  logic      push, q_ready, pop, q_valid;

  ius_derive u_derive (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .ctrl      (ctrl)
  );

  ius_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .ctrl      (ctrl),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_job  (push_job),
    .q_ready   (q_ready)
  );

  ius_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  ius_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .geom       (geom),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ design/ius_checker.sv @@
`timescale 1ns / 1ps

module ius_checker import ius_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_we,
  input logic [2:0]  cfg_index
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // a register write starts a geometry pass, so no pixel is taken next cycle
  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == REG_SRC_WIDTH || cfg_index == REG_SRC_HEIGHT ||
               cfg_index == REG_DST_WIDTH || cfg_index == REG_DST_HEIGHT ||
               cfg_index == REG_ROW_STRIDE) |=> !in_tready)
    else $error("input taken during geometry pass");

  // within a block the writes follow back to back
  a_block_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a block");

  // one source pixel: same color on every write of its block
  a_block_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tdata[38:23] == $past(out_tdata[38:23]))
    else $error("pixel changed inside a block");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind integer_upscaler_centered_rgb565 ius_checker u_ius_checker (.*);

@@ tb/tb_integer_upscaler_centered_rgb565.sv @@
`timescale 1ns / 1ps

module tb_integer_upscaler_centered_rgb565;
  import ius_pkg::*;

  localparam int StallLimit   = 3000;
  localparam int HoldCycles   = 250;
  localparam int RandomPixels = 130;
  localparam int SettleCycles = 16;
  localparam int MaxPrinted   = 40;

  // indexes past the register list, written to show they are ignored
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {STEP_PIXEL, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [2:0]  idx;
    logic [23:0] value;
    logic        typed;
    logic [15:0] pix565;
  } step_t;

  typedef struct packed {
    logic [22:0] addr;
    logic [15:0] pixel;
    logic        last;
  } fb_write_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [23:0] color
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [22:0] word_address, [38:23] pixel, [39] zero
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_wdata;

  integer_upscaler_centered_rgb565 u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // register copies and derived geometry
  logic [10:0] src_w_q;
  logic [9:0]  src_h_q;
  logic [11:0] dst_w_q;
  logic [11:0] dst_h_q;
  logic [12:0] stride_q;
  int unsigned eff_w, eff_h, scale_h, scale_v, clip_w, clip_v, off_h, off_v;
  int unsigned col_pos, row_pos;

  fb_write_t writes_q[$];
  fb_write_t want_w;
  step_t     plan_q[$];

  int  err_cnt     = 0;
  int  px_sent     = 0;
  int  writes_seen = 0;
  int  reg_writes  = 0;
  int  idle_cycles = 0;
  bit  steady;
  bit  hold_req;

  function automatic void fit_axis(input int unsigned src, input int unsigned dst,
                                   output int unsigned sc, output int unsigned clip,
                                   output int unsigned off);
    sc = dst / src;
    if (sc < 1) sc = 1;
    if (sc > MaxScale) sc = MaxScale;
    clip = (src > dst / sc) ? dst / sc : src;
    off = (dst > clip * sc) ? (dst - clip * sc) / 2 : 0;
  endfunction

  function automatic void rebuild_geometry();
    eff_w = (src_w_q == 0) ? 1 : (src_w_q > MaxSrcWidth) ? MaxSrcWidth : src_w_q;
    eff_h = (src_h_q == 0) ? 1 : (src_h_q > MaxSrcHeight) ? MaxSrcHeight : src_h_q;
    fit_axis(eff_w, dst_w_q, scale_h, clip_w, off_h);
    fit_axis(eff_h, dst_h_q, scale_v, clip_v, off_v);
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [12:0] val);
    case (idx)
      REG_SRC_WIDTH:  src_w_q  = val[10:0];
      REG_SRC_HEIGHT: src_h_q  = val[9:0];
      REG_DST_WIDTH:  dst_w_q  = val[11:0];
      REG_DST_HEIGHT: dst_h_q  = val[11:0];
      REG_ROW_STRIDE: stride_q = val;
      default: return;
    endcase
    rebuild_geometry();
  endfunction

  function automatic logic [15:0] rgb565_of(input logic [23:0] c);
    logic [7:0] r, g, b;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // queue the block of framebuffer writes for an in-clip source pixel, then advance
  function automatic void expand_pixel(input logic [15:0] pix);
    int unsigned row, col, addr;
    fb_write_t w;
    if (col_pos < clip_w && row_pos < clip_v) begin
      for (int unsigned sy = 0; sy < scale_v; sy++) begin
        row = off_v + row_pos * scale_v + sy;
        for (int unsigned sx = 0; sx < scale_h; sx++) begin
          col = off_h + col_pos * scale_h + sx;
          addr = row * stride_q + col;
          w.addr = addr[22:0];
          w.pixel = pix;
          w.last = (sy == scale_v - 1) && (sx == scale_h - 1);
          writes_q.push_back(w);
        end
      end
    end
    col_pos++;
    if (col_pos >= eff_w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= eff_h) row_pos = 0;
    end
  endfunction

  function automatic void add_pixel(input logic [23:0] color, input logic typed,
                                    input logic [15:0] pix565);
    step_t s;
    s.kind = STEP_PIXEL;
    s.idx = '0;
    s.value = color;
    s.typed = typed;
    s.pix565 = pix565;
    plan_q.push_back(s);
  endfunction

  function automatic void add_reg(input logic [2:0] idx, input logic [12:0] val);
    step_t s;
    s.kind = STEP_REG;
    s.idx = idx;
    s.value = {11'd0, val};
    s.typed = 1'b0;
    s.pix565 = '0;
    plan_q.push_back(s);
  endfunction

  function automatic logic [12:0] pick_dim(input int unsigned small_max);
    case ($urandom_range(9))
      0:       return 13'd0;
      1, 2:    return 13'($urandom_range(0, 8191));
      default: return 13'($urandom_range(1, small_max));
    endcase
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrinted)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // called after a posedge; valid stays high across back-to-back beats
  task automatic send_pixel(input logic [23:0] color, input logic [15:0] pix);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 21) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= color;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    px_sent++;
    expand_pixel(pix);
  endtask

  // stop offering, wait for all writes, then let out-of-clip pixels finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (writes_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    store_reg(idx, val);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      writes_seen++;
      if (writes_q.size() == 0) begin
        log_mismatch("write with nothing pending", {9'd0, out_tdata[22:0]}, 32'd0);
      end else begin
        want_w = writes_q.pop_front();
        if (out_tdata[22:0] !== want_w.addr)
          log_mismatch("word_address", {9'd0, out_tdata[22:0]}, {9'd0, want_w.addr});
        if (out_tdata[38:23] !== want_w.pixel)
          log_mismatch("pixel", {16'd0, out_tdata[38:23]}, {16'd0, want_w.pixel});
        if (out_tlast !== want_w.last)
          log_mismatch("last", {31'd0, out_tlast}, {31'd0, want_w.last});
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= steady || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Timeout: no beat for %0d cycles, %0d writes pending", StallLimit,
               writes_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    step_t st;
    bit    after_px;
    int    phase;
    int    rand_px;
    int    n_items;
    logic [23:0] c;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady    = 1'b0;
    hold_req  = 1'b0;

    src_w_q  = 11'd320;
    src_h_q  = 10'd256;
    dst_w_q  = 12'd640;
    dst_h_q  = 12'd512;
    stride_q = 13'd640;
    rebuild_geometry();

    // reset geometry is 2x2, no offset: color extremes with known RGB565
    add_pixel(24'h000000, 1'b1, 16'h0000);
    add_pixel(24'hFFFFFF, 1'b1, 16'hFFFF);
    add_pixel(24'hFF0000, 1'b1, 16'hF800);
    add_pixel(24'h00FF00, 1'b1, 16'h07E0);
    add_pixel(24'h0000FF, 1'b1, 16'h001F);
    add_pixel(24'h070307, 1'b1, 16'h0000);
    add_pixel(24'h080408, 1'b1, 16'h0821);
    // 2x3 source: column 1 clipped, vertical centering, zero stride, frame wrap
    add_reg(REG_SRC_WIDTH, 13'd2);
    add_reg(REG_SRC_HEIGHT, 13'd3);
    add_reg(REG_DST_WIDTH, 13'd1);
    add_reg(REG_DST_HEIGHT, 13'd8);
    add_reg(REG_ROW_STRIDE, 13'd0);
    add_pixel(24'h123456, 1'b0, '0);
    add_pixel(24'hA5A5A5, 1'b0, '0);
    add_pixel(24'h5A5A5A, 1'b0, '0);
    add_pixel(24'hC0FFEE, 1'b0, '0);
    add_pixel(24'h0F0F0F, 1'b0, '0);
    add_pixel(24'hF0F0F0, 1'b0, '0);
    add_pixel(24'h808080, 1'b0, '0);
    // 1x1 source in the largest framebuffer: scale saturates, addresses wrap
    add_reg(REG_SRC_WIDTH, 13'd1);
    add_reg(REG_SRC_HEIGHT, 13'd1);
    add_reg(REG_DST_WIDTH, 13'd4095);
    add_reg(REG_DST_HEIGHT, 13'd4095);
    add_reg(REG_ROW_STRIDE, 13'd8191);
    add_pixel(24'hFFFFFF, 1'b1, 16'hFFFF);
    add_pixel(24'h000000, 1'b1, 16'h0000);
    // zero source size, zero framebuffer width: no writes; spare indexes ignored
    add_reg(REG_SRC_WIDTH, 13'd0);
    add_reg(REG_SRC_HEIGHT, 13'd0);
    add_reg(REG_DST_WIDTH, 13'd0);
    add_reg(REG_SPARE_LO, 13'h1ABC);
    add_reg(REG_SPARE_HI, 13'h0543);
    add_pixel(24'h3C3C3C, 1'b0, '0);
    add_pixel(24'hC3C3C3, 1'b0, '0);
    // all-ones writes: masked, then source clamped to the maximum size
    add_reg(REG_SRC_WIDTH, 13'h1FFF);
    add_reg(REG_SRC_HEIGHT, 13'h1FFF);
    add_reg(REG_DST_WIDTH, 13'h1FFF);
    add_reg(REG_DST_HEIGHT, 13'd1);
    add_reg(REG_ROW_STRIDE, 13'h1FFF);
    add_pixel(24'h7F7F7F, 1'b0, '0);
    add_pixel(24'h818181, 1'b0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    after_px = 1'b0;
    foreach (plan_q[i]) begin
      st = plan_q[i];
      if (st.kind == STEP_REG) begin
        if (after_px) settle();
        after_px = 1'b0;
        write_reg(st.idx, st.value[12:0]);
      end else begin
        send_pixel(st.value, st.typed ? st.pix565 : rgb565_of(st.value));
        after_px = 1'b1;
      end
    end

    phase = 0;
    rand_px = 0;
    while (rand_px < RandomPixels) begin
      settle();
      if (phase == 1) begin
        // 4x4 into 8x8: every pixel writes, so a stalled receiver backs up the input
        write_reg(REG_SRC_WIDTH, 13'd4);
        write_reg(REG_SRC_HEIGHT, 13'd4);
        write_reg(REG_DST_WIDTH, 13'd8);
        write_reg(REG_DST_HEIGHT, 13'd8);
        write_reg(REG_ROW_STRIDE, 13'd8);
        hold_req = 1'b1;
      end else begin
        write_reg(REG_SRC_WIDTH, pick_dim(8));
        write_reg(REG_SRC_HEIGHT, pick_dim(8));
        write_reg(REG_DST_WIDTH, pick_dim(40));
        write_reg(REG_DST_HEIGHT, pick_dim(40));
        write_reg(REG_ROW_STRIDE, pick_dim(64));
        if ($urandom_range(3) == 0)
          write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                    13'($urandom_range(0, 8191)));
      end
      steady = (phase == 3);
      n_items = $urandom_range(8, 24);
      if (n_items > RandomPixels - rand_px) n_items = RandomPixels - rand_px;
      repeat (n_items) begin
        c = 24'($urandom);
        send_pixel(c, rgb565_of(c));
        rand_px++;
      end
      phase++;
    end

    settle();
    steady = 1'b0;
    $display("Sent %0d source pixels over %0d geometry phases, %0d register writes,",
             px_sent, phase + 5, reg_writes);
    $display("checked %0d framebuffer writes, %0d mismatches", writes_seen, err_cnt);
    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
